// ===== rtl/bcp_pkg.sv =====
// Shared types and constants for the cubic Bezier curve plotter.
package bcp_pkg;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CoordW = 16;
  localparam int unsigned SpanW  = 17;
  localparam int unsigned XW     = 18;

  typedef enum logic [2:0] {
    REG_START_X = 3'd0,
    REG_SPAN    = 3'd1,
    REG_START_Y = 3'd2,
    REG_CTRL1_Y = 3'd3,
    REG_CTRL2_Y = 3'd4,
    REG_END_Y   = 3'd5
  } reg_addr_e;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [SpanW-1:0]  span;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] ctrl1_y;
    logic signed [CoordW-1:0] ctrl2_y;
    logic signed [CoordW-1:0] end_y;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DIV,
    PH_MUL,
    PH_SUM,
    PH_OUT
  } phase_e;

  typedef enum logic [3:0] {
    OP_UU = 4'd0,
    OP_TT = 4'd1,
    OP_W0 = 4'd2,
    OP_W1 = 4'd3,
    OP_W2 = 4'd4,
    OP_W3 = 4'd5,
    OP_Y0 = 4'd6,
    OP_Y1 = 4'd7,
    OP_Y2 = 4'd8,
    OP_Y3 = 4'd9
  } mul_op_e;

endpackage

// ===== rtl/bcp_cfg.sv =====
// APB-style configuration register file for the curve plotter.
module bcp_cfg
  import bcp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output logic [DataW-1:0] prdata_o,
  output cfg_t             cfg_o
);

  cfg_t      cfg_q, cfg_d;
  logic      wr_en;
  reg_addr_e idx;

  assign idx   = reg_addr_e'(paddr_i[AddrW-1:2]);
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_START_X: cfg_d.start_x = pwdata_i[CoordW-1:0];
        REG_SPAN:    cfg_d.span    = pwdata_i[SpanW-1:0];
        REG_START_Y: cfg_d.start_y = pwdata_i[CoordW-1:0];
        REG_CTRL1_Y: cfg_d.ctrl1_y = pwdata_i[CoordW-1:0];
        REG_CTRL2_Y: cfg_d.ctrl2_y = pwdata_i[CoordW-1:0];
        REG_END_Y:   cfg_d.end_y   = pwdata_i[CoordW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_X: prdata_o = DataW'(cfg_q.start_x);
      REG_SPAN:    prdata_o = DataW'(cfg_q.span);
      REG_START_Y: prdata_o = DataW'(cfg_q.start_y);
      REG_CTRL1_Y: prdata_o = DataW'(cfg_q.ctrl1_y);
      REG_CTRL2_Y: prdata_o = DataW'(cfg_q.ctrl2_y);
      REG_END_Y:   prdata_o = DataW'(cfg_q.end_y);
      default:     prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bcp_div.sv =====
// Restoring divider: quotient of (num << (QW-1)) / den for num <= den, one bit a cycle.
module bcp_div
  import bcp_pkg::*;
#(
  parameter int unsigned QW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SpanW-1:0] num_i,
  input  logic [SpanW-1:0] den_i,
  output logic             done_o,
  output logic [QW-1:0]    quo_o
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic             busy_q, busy_d;
  logic             first_q, first_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [SpanW-1:0] rem_q, rem_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [SpanW:0]   shifted, diff;
  logic             ge;

  always_comb begin
    shifted = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
    diff    = shifted - {1'b0, den_i};
    ge      = shifted >= {1'b0, den_i};
  end

  always_comb begin
    busy_d  = busy_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    done_d  = 1'b0;
    if (start_i) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = CW'(QW);
      rem_d   = num_i;
      quo_d   = '0;
    end else if (busy_q) begin
      first_d = 1'b0;
      rem_d   = ge ? diff[SpanW-1:0] : shifted[SpanW-1:0];
      quo_d   = {quo_q[QW-2:0], ge};
      cnt_d   = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      first_q <= first_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/bcp_mul.sv =====
// Shared signed multiplier with a registered product.
module bcp_mul #(
  parameter int unsigned OPW = 19
) (
  input  logic                  clk_i,
  input  logic signed [OPW-1:0]   a_i,
  input  logic signed [OPW-1:0]   b_i,
  output logic signed [2*OPW-1:0] prod_o
);

  logic signed [2*OPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/cubic_bezier_curve_plotter.sv =====
// Cubic Bezier curve plotter: emits at most one line segment of y(x) per advance transfer.
//
// Each advance that yields a segment goes from input transfer to output
// register through the bit-serial divider that forms t = i/span, ten passes
// through the single shared multiplier for the Bernstein weights and the
// weighted sum, and the sum and output phases that accumulate, round toward
// zero, saturate and load the result.
// A restart, or an advance that yields no segment, does not enter the divider.
// The input stalls while a segment is in work; a finished segment waits in
// the output register without blocking the next input transfer.
module cubic_bezier_curve_plotter
  import bcp_pkg::*;
#(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     restart_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [XW-1:0]     seg_x0_o,
  output logic signed [CoordW-1:0] seg_y0_o,
  output logic signed [XW-1:0]     seg_x1_o,
  output logic signed [CoordW-1:0] seg_y1_o,
  output logic                     last_o
);

  localparam int unsigned F    = T_FRAC_BITS;
  localparam int unsigned TW   = F + 1;
  localparam int unsigned WW   = F + 2;
  localparam int unsigned OPW  = (F + 3 > CoordW) ? F + 3 : CoordW;
  localparam int unsigned PW   = 2 * OPW;
  localparam int unsigned ACCW = PW + 2;
  localparam logic [TW-1:0] One = TW'(64'd1 << F);
  localparam logic signed [ACCW-1:0] Rnd  = ACCW'((64'd1 << F) - 64'd1);
  localparam logic signed [ACCW-1:0] YHi  = ACCW'((64'd1 << (COORD_BITS - 1)) - 64'd1);
  localparam logic signed [ACCW-1:0] YLo  = -YHi - ACCW'(1);

  cfg_t cfg;

  bcp_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  phase_e  phase_q, phase_d;
  mul_op_e op_q, op_d, wb_op_q, wb_op_d;
  logic    wb_vld_q, wb_vld_d;

  logic [SpanW-1:0]         step_q, step_d;
  logic signed [CoordW-1:0] prev_y_q, prev_y_d;
  logic                     fin_q, fin_d;

  logic [TW-1:0]         t_q, t_d, u_q, u_d, uu_q, uu_d, tt_q, tt_d;
  logic [TW-1:0]         w0_q, w0_d, w3_q, w3_d;
  logic [WW-1:0]         w1_q, w1_d, w2_q, w2_d;
  logic signed [ACCW-1:0] acc_q, acc_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [XW-1:0]     x0_q, x0_d, x1_q, x1_d;
  logic signed [CoordW-1:0] y0_q, y0_d, y1_q, y1_d;
  logic                     last_q, last_d;

  logic                   accept, can_step, div_start, div_done, out_free, load;
  logic [TW-1:0]          quo;
  logic signed [OPW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]   prod;
  logic [TW-1:0]          prod_hi;
  logic signed [ACCW-1:0] acc_adj, y_full, y_sat;
  logic signed [XW-1:0]   x_base;
  logic                   is_last;

  bcp_div #(
    .QW (TW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (step_q),
    .den_i   (cfg.span),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  bcp_mul #(
    .OPW (OPW)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_stall_o = (phase_q != PH_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign can_step   = !fin_q && !cfg.span[SpanW-1] && (cfg.span != '0)
                      && ({1'b0, step_q} <= {1'b0, cfg.span});
  assign div_start  = accept && !restart_i && can_step;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = (phase_q == PH_OUT) && out_free;
  assign prod_hi    = prod[F +: TW];

  always_comb begin
    case (op_q)
      OP_UU:   begin mul_a = OPW'(u_q);  mul_b = OPW'(u_q);  end
      OP_TT:   begin mul_a = OPW'(t_q);  mul_b = OPW'(t_q);  end
      OP_W0:   begin mul_a = OPW'(uu_q); mul_b = OPW'(u_q);  end
      OP_W1:   begin mul_a = OPW'(uu_q); mul_b = OPW'(t_q);  end
      OP_W2:   begin mul_a = OPW'(u_q);  mul_b = OPW'(tt_q); end
      OP_W3:   begin mul_a = OPW'(tt_q); mul_b = OPW'(t_q);  end
      OP_Y0:   begin mul_a = OPW'(w0_q); mul_b = OPW'(cfg.start_y); end
      OP_Y1:   begin mul_a = OPW'(w1_q); mul_b = OPW'(cfg.ctrl1_y); end
      OP_Y2:   begin mul_a = OPW'(w2_q); mul_b = OPW'(cfg.ctrl2_y); end
      OP_Y3:   begin mul_a = OPW'(w3_q); mul_b = OPW'(cfg.end_y);   end
      default: begin mul_a = '0;         mul_b = '0;                end
    endcase
  end

  // sum / 2^F toward zero, then clamp to the coordinate range
  always_comb begin
    acc_adj = acc_q[ACCW-1] ? acc_q + Rnd : acc_q;
    y_full  = acc_adj >>> F;
    if (y_full > YHi) begin
      y_sat = YHi;
    end else if (y_full < YLo) begin
      y_sat = YLo;
    end else begin
      y_sat = y_full;
    end
  end

  always_comb begin
    x_base  = {{(XW-CoordW){cfg.start_x[CoordW-1]}}, cfg.start_x}
              + XW'({1'b0, step_q});
    is_last = (step_q == cfg.span[SpanW-1:0]);
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: if (div_start) phase_d = PH_DIV;
      PH_DIV:  if (div_done) phase_d = PH_MUL;
      PH_MUL:  if (op_q == OP_Y3) phase_d = PH_SUM;
      PH_SUM:  phase_d = PH_OUT;
      PH_OUT:  if (out_free) phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    wb_op_d     = wb_op_q;
    wb_vld_d    = 1'b0;
    step_d      = step_q;
    prev_y_d    = prev_y_q;
    fin_d       = fin_q;
    t_d         = t_q;
    u_d         = u_q;
    uu_d        = uu_q;
    tt_d        = tt_q;
    w0_d        = w0_q;
    w1_d        = w1_q;
    w2_d        = w2_q;
    w3_d        = w3_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    x0_d        = x0_q;
    x1_d        = x1_q;
    y0_d        = y0_q;
    y1_d        = y1_q;
    last_d      = last_q;

    if (accept && restart_i) begin
      step_d   = SpanW'(1);
      prev_y_d = cfg.start_y;
      fin_d    = 1'b0;
    end

    if (phase_q == PH_DIV && div_done) begin
      t_d  = quo;
      u_d  = One - quo;
      op_d = OP_UU;
    end

    if (phase_q == PH_MUL) begin
      wb_op_d  = op_q;
      wb_vld_d = 1'b1;
      op_d     = mul_op_e'(op_q + 4'd1);
    end

    if (wb_vld_q) begin
      case (wb_op_q)
        OP_UU:   uu_d  = prod_hi;
        OP_TT:   tt_d  = prod_hi;
        OP_W0:   w0_d  = prod_hi;
        OP_W1:   w1_d  = {1'b0, prod_hi} + {prod_hi, 1'b0};
        OP_W2:   w2_d  = {1'b0, prod_hi} + {prod_hi, 1'b0};
        OP_W3:   w3_d  = prod_hi;
        OP_Y0:   acc_d = ACCW'(prod);
        OP_Y1:   acc_d = acc_q + ACCW'(prod);
        OP_Y2:   acc_d = acc_q + ACCW'(prod);
        OP_Y3:   acc_d = acc_q + ACCW'(prod);
        default: acc_d = acc_q;
      endcase
    end

    if (load) begin
      out_valid_d = 1'b1;
      x0_d        = x_base;
      x1_d        = x_base + XW'(1);
      y0_d        = (step_q == SpanW'(1)) ? cfg.start_y : prev_y_q;
      y1_d        = y_sat[CoordW-1:0];
      last_d      = is_last;
      prev_y_d    = y_sat[CoordW-1:0];
      if (is_last) begin
        fin_d = 1'b1;
      end else begin
        step_d = step_q + SpanW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      op_q        <= OP_UU;
      wb_op_q     <= OP_UU;
      wb_vld_q    <= 1'b0;
      step_q      <= SpanW'(1);
      prev_y_q    <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      op_q        <= op_d;
      wb_op_q     <= wb_op_d;
      wb_vld_q    <= wb_vld_d;
      step_q      <= step_d;
      prev_y_q    <= prev_y_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    u_q    <= u_d;
    uu_q   <= uu_d;
    tt_q   <= tt_d;
    w0_q   <= w0_d;
    w1_q   <= w1_d;
    w2_q   <= w2_d;
    w3_q   <= w3_d;
    acc_q  <= acc_d;
    x0_q   <= x0_d;
    x1_q   <= x1_d;
    y0_q   <= y0_d;
    y1_q   <= y1_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign seg_x0_o    = x0_q;
  assign seg_y0_o    = y0_q;
  assign seg_x1_o    = x1_q;
  assign seg_y1_o    = y1_q;
  assign last_o      = last_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the cubic Bezier curve plotter: segments predicted per transfer and checked in order.
module tb_top;
  import bcp_pkg::*;

  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned FRAC        = 16;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [2:0]  REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic signed [XW-1:0]     x0;
    logic signed [CoordW-1:0] y0;
    logic signed [XW-1:0]     x1;
    logic signed [CoordW-1:0] y1;
    logic                     last;
  } seg_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrW-1:0]         paddr;
  logic [DataW-1:0]         pwdata;
  logic [DataW-1:0]         prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     restart_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [XW-1:0]     seg_x0_o;
  logic signed [CoordW-1:0] seg_y0_o;
  logic signed [XW-1:0]     seg_x1_o;
  logic signed [CoordW-1:0] seg_y1_o;
  logic                     last_o;

  // shadow registers and curve state
  logic signed [CoordW-1:0] c_start_x = '0;
  logic signed [SpanW-1:0]  c_span    = '0;
  logic signed [CoordW-1:0] c_start_y = '0;
  logic signed [CoordW-1:0] c_ctrl1_y = '0;
  logic signed [CoordW-1:0] c_ctrl2_y = '0;
  logic signed [CoordW-1:0] c_end_y   = '0;
  logic [SpanW-1:0]         pl_step   = SpanW'(1);
  logic signed [CoordW-1:0] pl_prev   = '0;
  logic                     pl_done   = 1'b0;

  seg_t seg_q[$];
  int   errors        = 0;
  int   n_useful      = 0;
  int   snd_idle_pct  = 0;
  int   rcv_stall_pct = 0;
  int   hold_len      = 0;

  cubic_bezier_curve_plotter #(
    .COORD_BITS  (16),
    .T_FRAC_BITS (16)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .seg_x0_o    (seg_x0_o),
    .seg_y0_o    (seg_y0_o),
    .seg_x1_o    (seg_x1_o),
    .seg_y1_o    (seg_y1_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic logic signed [CoordW-1:0] curve_y(input int unsigned i,
                                                       input int unsigned n);
    longint unsigned one, ti, t, u, uu, tt;
    longint w0, w1, w2, w3, sum, y, hi, lo;
    one = 64'd1 << FRAC;
    ti  = 64'(i);
    t   = (ti << FRAC) / n;
    if (t > one) t = one;
    u  = one - t;
    uu = (u * u) >> FRAC;
    tt = (t * t) >> FRAC;
    w0 = longint'((uu * u) >> FRAC);
    w1 = 3 * longint'((uu * t) >> FRAC);
    w2 = 3 * longint'((u * tt) >> FRAC);
    w3 = longint'((tt * t) >> FRAC);
    sum = w0 * longint'(c_start_y) + w1 * longint'(c_ctrl1_y)
        + w2 * longint'(c_ctrl2_y) + w3 * longint'(c_end_y);
    y  = sum / longint'(one);
    hi = (longint'(1) <<< (CoordW - 1)) - 1;
    lo = -hi - 1;
    if (y > hi) y = hi;
    if (y < lo) y = lo;
    return y[CoordW-1:0];
  endfunction

  task automatic plot_step(input logic rs);
    int   sp, stp, x0;
    seg_t s;
    sp  = int'(c_span);
    stp = int'(pl_step);
    if (rs) begin
      pl_step = SpanW'(1);
      pl_prev = c_start_y;
      pl_done = 1'b0;
      n_useful++;
      return;
    end
    if (pl_done || sp <= 0 || stp > sp) return;
    x0     = c_start_x + stp;
    s.x0   = XW'(x0);
    s.x1   = XW'(x0 + 1);
    s.y0   = (stp == 1) ? c_start_y : pl_prev;
    s.y1   = curve_y(stp, sp);
    s.last = (stp == sp);
    pl_prev = s.y1;
    if (s.last) pl_done = 1'b1;
    else pl_step = pl_step + 1'b1;
    seg_q.push_back(s);
    n_useful++;
  endtask

  function automatic int reg_width(input logic [2:0] idx);
    return (idx == REG_SPAN) ? SpanW : CoordW;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input int val);
    logic [DataW-1:0] mask, got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_START_X: c_start_x = val[CoordW-1:0];
      REG_SPAN:    c_span    = val[SpanW-1:0];
      REG_START_Y: c_start_y = val[CoordW-1:0];
      REG_CTRL1_Y: c_ctrl1_y = val[CoordW-1:0];
      REG_CTRL2_Y: c_ctrl2_y = val[CoordW-1:0];
      REG_END_Y:   c_end_y   = val[CoordW-1:0];
      default: ;
    endcase
    if (idx == REG_UNMAPPED) return;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= $urandom;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    mask = DataW'((64'd1 << reg_width(idx)) - 64'd1);
    if ((got & mask) !== (DataW'(val) & mask)) begin
      errors++;
      $display("%0t readback reg %0d mismatch: expected %0h actual %0h", $time, idx,
               DataW'(val) & mask, got & mask);
    end
  endtask

  task automatic send_item(input logic rs);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(0, 1));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    plot_step(rs);
  endtask

  // stop offering, wait out every expected segment, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (seg_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic int pick_coord();
    logic signed [CoordW-1:0] v;
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: begin
        v = CoordW'($urandom);
        return int'(v);
      end
    endcase
  endfunction

  task automatic cfg_curve(input int sx, input int sp, input int y0, input int y1,
                           input int y2, input int y3);
    cfg_write(REG_START_X, sx);
    cfg_write(REG_SPAN, sp);
    cfg_write(REG_START_Y, y0);
    cfg_write(REG_CTRL1_Y, y1);
    cfg_write(REG_CTRL2_Y, y2);
    cfg_write(REG_END_Y, y3);
  endtask

  task automatic cmp_field(input string name, input logic signed [63:0] want,
                           input logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : seg_check
    seg_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (seg_q.size() == 0) begin
        errors++;
        $display("%0t unexpected segment: expected none actual x0 %0d y0 %0d", $time,
                 seg_x0_o, seg_y0_o);
      end else begin
        e = seg_q.pop_front();
        cmp_field("seg_x0", 64'(e.x0), 64'(seg_x0_o));
        cmp_field("seg_y0", 64'(e.y0), 64'(seg_y0_o));
        cmp_field("seg_x1", 64'(e.x1), 64'(seg_x1_o));
        cmp_field("seg_y1", 64'(e.y1), 64'(seg_y1_o));
        cmp_field("last", 64'(e.last), 64'(last_o));
      end
    end
  end

  initial begin : receiver
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        repeat (n) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic test_reset_state();
    send_item(1'b0);
    send_item(1'b1);
  endtask

  task automatic test_extremes();
    drain();
    cfg_curve(-32768, 3, -32768, 32767, -32768, 32767);
    send_item(1'b1);
    repeat (4) send_item(1'b0);
    drain();
    cfg_curve(32767, 1, 32767, 32767, 32767, 32767);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_nonpositive_span();
    drain();
    cfg_write(REG_SPAN, 0);
    send_item(1'b0);
    drain();
    cfg_write(REG_SPAN, -1);
    cfg_write(REG_UNMAPPED, 32'h5a5a_a5a5);
    send_item(1'b0);
    drain();
    cfg_write(REG_SPAN, -65535);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_midcurve_writes();
    drain();
    cfg_curve(1000, 5, 100, -2000, 3000, -400);
    send_item(1'b1);
    drain();
    cfg_write(REG_START_Y, 12345);
    send_item(1'b0);
    send_item(1'b0);
    drain();
    cfg_write(REG_CTRL2_Y, -32768);
    cfg_write(REG_START_X, -5);
    send_item(1'b0);
    drain();
    cfg_write(REG_SPAN, 2);
    send_item(1'b0);
    drain();
    cfg_write(REG_SPAN, 65535);
    send_item(1'b0);
    send_item(1'b0);
  endtask

  task automatic test_max_span();
    drain();
    cfg_curve(32767, 65535, -32768, 32767, 32767, -32768);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
  endtask

  task automatic test_backpressure();
    drain();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    cfg_curve(pick_coord(), 12, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    send_item(1'b1);
    hold_len = HOLD_CYCLES;
    repeat (12) send_item(1'b0);
    drain();
    cfg_write(REG_SPAN, 8);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    in_valid_i <= 1'b0;
    while (seg_q.size() != 0) @(posedge clk_i);
    repeat (6) send_item(1'b0);
  endtask

  task automatic test_random(input int idle, input int stall, input int target);
    int         goal, steps, r, sp, v;
    logic [2:0] idx;
    drain();
    snd_idle_pct  = idle;
    rcv_stall_pct = stall;
    goal = n_useful + target;
    while (n_useful < goal) begin
      drain();
      r = $urandom_range(0, 99);
      if (r < 70) sp = $urandom_range(1, 12);
      else if (r < 82) sp = $urandom_range(13, 60);
      else if (r < 88) sp = -int'($urandom_range(0, 65535));
      else if (r < 94) sp = $urandom_range(65000, 65535);
      else sp = 65535;
      cfg_curve(pick_coord(), sp, pick_coord(), pick_coord(), pick_coord(), pick_coord());
      if ($urandom_range(0, 9) != 0) send_item(1'b1);
      steps = (sp > 0 && sp <= 60) ? sp + $urandom_range(0, 2) : $urandom_range(1, 4);
      repeat (steps) begin
        if ($urandom_range(0, 99) < 3) begin
          drain();
          idx = 3'($urandom_range(0, 5));
          v   = (idx == REG_SPAN) ? $urandom_range(1, 16) : pick_coord();
          cfg_write(idx, v);
        end
        send_item($urandom_range(0, 99) < 4);
      end
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    restart_i  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_extremes();
    test_nonpositive_span();
    test_midcurve_writes();
    test_max_span();
    test_backpressure();
    test_random(0, 0, 130);
    test_random(81, 0, 130);
    test_random(0, 81, 130);
    test_random(30, 30, 130);
    drain();
    if (errors == 0 && seg_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
